FILE: rtl/zps_pkg.sv
package zps_pkg;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF  = 8;
  localparam int NUM_PROGRAMS_DEF = 16;
  localparam int MAX_ZONES_DEF    = 16;
  localparam int NUM_VALVES_DEF   = 64;

  // Fixed field widths
  localparam int OP_W    = 4;
  localparam int SLOT_W  = 4;
  localparam int ID_W    = 16;
  localparam int SIDX_W  = 4;
  localparam int VALVE_W = 6;
  localparam int DUR_W   = 16;
  localparam int TOT_W   = 5;
  localparam int QCNT_W  = 4;
  localparam int ZENT_W  = VALVE_W + DUR_W;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 4'd0,
    OP_ENQ    = 4'd1,
    OP_NZONE  = 4'd2,
    OP_NPROG  = 4'd3,
    OP_STOP   = 4'd4,
    OP_CANCEL = 4'd5,
    OP_QUERY  = 4'd6,
    OP_WPROG  = 4'd7,
    OP_WZONE  = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_IGNORE = 2'd1,
    ST_FULL   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // Datapath actions issued by the controller
  typedef enum logic [4:0] {
    A_NONE,
    A_DEC,
    A_ENQ,
    A_STOP,
    A_WPROG,
    A_WZONE,
    A_NZREAD,
    A_POP,
    A_GO,
    A_IDLE,
    A_LOAD,
    A_SCAN0,
    A_STEP,
    A_QSTEP,
    A_SHIFT,
    A_SHEND,
    A_RESP
  } dp_act_t;

  typedef struct packed {
    logic    take;
    dp_act_t act;
    logic    status_we;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic            in_fire;
    logic [OP_W-1:0] opcode;
    logic            count_zero;
    logic            cd_le1;
    logic            cur_match;
    logic            step_match;
    logic            enq_range;
    logic            enq_full;
    logic            wprog_err;
    logic            wzone_err;
    logic            nz_ok;
    logic            head_ok;
    logic            scan_end;
    logic            cancel_hit;
    logic            k_zero;
    logic            shift_end;
    logic            out_free;
  } dp_stat_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_NZ     = 10'b0000000100,
    S_NP     = 10'b0000001000,
    S_LAUNCH = 10'b0000010000,
    S_ZLOAD  = 10'b0000100000,
    S_CSCAN  = 10'b0001000000,
    S_SHIFT  = 10'b0010000000,
    S_QSCAN  = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_t;

endpackage

FILE: rtl/zps_if.sv
interface zps_item_if;
  logic                        valid;
  logic                        ready;
  logic [zps_pkg::OP_W-1:0]    opcode;
  logic [zps_pkg::SLOT_W-1:0]  prog_slot;
  logic [zps_pkg::ID_W-1:0]    run_id;
  logic [zps_pkg::SIDX_W-1:0]  step_index;
  logic [zps_pkg::VALVE_W-1:0] valve_number;
  logic [zps_pkg::DUR_W-1:0]   duration_secs;
  logic                        prog_valid;
  logic [zps_pkg::TOT_W-1:0]   step_total;

  modport source (output valid, opcode, prog_slot, run_id, step_index, valve_number,
                  duration_secs, prog_valid, step_total, input ready);
  modport sink (input valid, opcode, prog_slot, run_id, step_index, valve_number,
                duration_secs, prog_valid, step_total, output ready);
endinterface

interface zps_result_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic                        running;
  logic                        pump_on;
  logic                        valve_active;
  logic [zps_pkg::VALVE_W-1:0] valve_open_id;
  logic [zps_pkg::SLOT_W-1:0]  active_program;
  logic [zps_pkg::SIDX_W-1:0]  active_step;
  logic [zps_pkg::DUR_W-1:0]   seconds_left;
  logic [zps_pkg::QCNT_W-1:0]  queued_runs;
  logic [zps_pkg::ID_W-1:0]    new_run_id;
  logic                        in_use;

  modport source (output valid, status, running, pump_on, valve_active, valve_open_id,
                  active_program, active_step, seconds_left, queued_runs, new_run_id,
                  in_use, input ready);
  modport sink (input valid, status, running, pump_on, valve_active, valve_open_id,
                active_program, active_step, seconds_left, queued_runs, new_run_id,
                in_use, output ready);
endinterface

FILE: rtl/zps_ctrl.sv
module zps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  zps_pkg::dp_stat_t st,
  output zps_pkg::dp_cmd_t  ctl
);

  zps_pkg::state_t state, state_next;

  // Sequence one word through decode, walks and response
  always_comb begin
    state_next    = state;
    ctl.take      = 1'b0;
    ctl.act       = zps_pkg::A_NONE;
    ctl.status_we = 1'b0;
    ctl.status    = zps_pkg::ST_DONE;
    unique case (state)
      zps_pkg::S_IDLE: begin
        ctl.take = 1'b1;
        if (st.in_fire) state_next = zps_pkg::S_DECODE;
      end
      zps_pkg::S_DECODE: begin
        state_next = zps_pkg::S_RESP;
        case (st.opcode)
          zps_pkg::OP_TICK: begin
            if (!st.count_zero) begin
              if (st.cd_le1) state_next = zps_pkg::S_NZ;
              else ctl.act = zps_pkg::A_DEC;
            end
          end
          zps_pkg::OP_ENQ: begin
            if (st.enq_range) begin
              ctl.status_we = 1'b1;
              ctl.status    = zps_pkg::ST_RANGE;
            end else if (st.enq_full) begin
              ctl.status_we = 1'b1;
              ctl.status    = zps_pkg::ST_FULL;
            end else begin
              ctl.act = zps_pkg::A_ENQ;
              if (st.count_zero) state_next = zps_pkg::S_LAUNCH;
            end
          end
          zps_pkg::OP_NZONE: begin
            if (st.cur_match && st.step_match) begin
              state_next = zps_pkg::S_NZ;
            end else begin
              ctl.status_we = 1'b1;
              ctl.status    = zps_pkg::ST_IGNORE;
            end
          end
          zps_pkg::OP_NPROG: begin
            if (st.cur_match) begin
              state_next = zps_pkg::S_NP;
            end else begin
              ctl.status_we = 1'b1;
              ctl.status    = zps_pkg::ST_IGNORE;
            end
          end
          zps_pkg::OP_STOP: ctl.act = zps_pkg::A_STOP;
          zps_pkg::OP_CANCEL: begin
            ctl.act    = zps_pkg::A_SCAN0;
            state_next = zps_pkg::S_CSCAN;
          end
          zps_pkg::OP_QUERY: begin
            ctl.act    = zps_pkg::A_SCAN0;
            state_next = zps_pkg::S_QSCAN;
          end
          zps_pkg::OP_WPROG: begin
            if (st.wprog_err) begin
              ctl.status_we = 1'b1;
              ctl.status    = zps_pkg::ST_RANGE;
            end else begin
              ctl.act = zps_pkg::A_WPROG;
            end
          end
          zps_pkg::OP_WZONE: begin
            if (st.wzone_err) begin
              ctl.status_we = 1'b1;
              ctl.status    = zps_pkg::ST_RANGE;
            end else begin
              ctl.act = zps_pkg::A_WZONE;
            end
          end
          default: begin
            ctl.status_we = 1'b1;
            ctl.status    = zps_pkg::ST_IGNORE;
          end
        endcase
      end
      zps_pkg::S_NZ: begin
        if (st.nz_ok) begin
          ctl.act    = zps_pkg::A_NZREAD;
          state_next = zps_pkg::S_ZLOAD;
        end else begin
          ctl.act    = zps_pkg::A_POP;
          state_next = zps_pkg::S_LAUNCH;
        end
      end
      zps_pkg::S_NP: begin
        ctl.act    = zps_pkg::A_POP;
        state_next = zps_pkg::S_LAUNCH;
      end
      zps_pkg::S_LAUNCH: begin
        priority if (st.count_zero) begin
          ctl.act    = zps_pkg::A_IDLE;
          state_next = zps_pkg::S_RESP;
        end else if (!st.head_ok) begin
          ctl.act = zps_pkg::A_POP;
        end else begin
          ctl.act    = zps_pkg::A_GO;
          state_next = zps_pkg::S_ZLOAD;
        end
      end
      zps_pkg::S_ZLOAD: begin
        ctl.act    = zps_pkg::A_LOAD;
        state_next = zps_pkg::S_RESP;
      end
      zps_pkg::S_CSCAN: begin
        priority if (st.scan_end) begin
          ctl.status_we = 1'b1;
          ctl.status    = zps_pkg::ST_IGNORE;
          state_next    = zps_pkg::S_RESP;
        end else if (st.cancel_hit) begin
          state_next = st.k_zero ? zps_pkg::S_NP : zps_pkg::S_SHIFT;
        end else begin
          ctl.act = zps_pkg::A_STEP;
        end
      end
      zps_pkg::S_SHIFT: begin
        if (st.shift_end) begin
          ctl.act    = zps_pkg::A_SHEND;
          state_next = zps_pkg::S_RESP;
        end else begin
          ctl.act = zps_pkg::A_SHIFT;
        end
      end
      zps_pkg::S_QSCAN: begin
        if (st.scan_end) state_next = zps_pkg::S_RESP;
        else ctl.act = zps_pkg::A_QSTEP;
      end
      zps_pkg::S_RESP: begin
        if (st.out_free) begin
          ctl.act    = zps_pkg::A_RESP;
          state_next = zps_pkg::S_IDLE;
        end
      end
      default: state_next = zps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= zps_pkg::S_IDLE;
    else state <= state_next;
  end

endmodule

FILE: rtl/zps_datapath.sv
module zps_datapath #(
  parameter int QUEUE_DEPTH  = zps_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_PROGRAMS = zps_pkg::NUM_PROGRAMS_DEF,
  parameter int MAX_ZONES    = zps_pkg::MAX_ZONES_DEF,
  parameter int NUM_VALVES   = zps_pkg::NUM_VALVES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  zps_item_if.sink          cmd,
  zps_result_if.source      rsp,
  input  zps_pkg::dp_cmd_t  ctl,
  output zps_pkg::dp_stat_t st
);

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;
  localparam int ZW = $clog2(MAX_ZONES + 1);
  localparam int ZD = NUM_PROGRAMS * MAX_ZONES;
  localparam int AW = (ZD > 1) ? $clog2(ZD) : 1;

  // Latched input word
  logic [zps_pkg::OP_W-1:0]    op_q;
  logic [zps_pkg::SLOT_W-1:0]  slot_q;
  logic [zps_pkg::ID_W-1:0]    rid_q;
  logic [zps_pkg::SIDX_W-1:0]  sidx_q;
  logic [zps_pkg::VALVE_W-1:0] valve_q;
  logic [zps_pkg::DUR_W-1:0]   dur_q;
  logic                        pval_q;
  logic [zps_pkg::TOT_W-1:0]   ptot_q;

  // Queue and run state
  logic [zps_pkg::ID_W-1:0]   qid   [QUEUE_DEPTH];
  logic [zps_pkg::SLOT_W-1:0] qprog [QUEUE_DEPTH];
  logic [HW-1:0]              head;
  logic [CW-1:0]              count;
  logic [CW-1:0]              k;
  logic [zps_pkg::ID_W-1:0]   idc;
  logic                       pump;
  logic [ZW-1:0]              step_pos;
  logic [ZW-1:0]              zpos;
  logic                       valve_on;
  logic [zps_pkg::VALVE_W-1:0] valve_id;
  logic [zps_pkg::DUR_W-1:0]  countdown;

  // Program table and zone store
  logic                       hdr_valid [NUM_PROGRAMS];
  logic [zps_pkg::TOT_W-1:0]  hdr_cnt   [NUM_PROGRAMS];
  logic [zps_pkg::ZENT_W-1:0] zmem      [ZD];
  logic [zps_pkg::ZENT_W-1:0] zrd;

  // Result fields
  zps_pkg::status_t           status;
  logic [zps_pkg::ID_W-1:0]   new_id;
  logic                       use_flag;

  function automatic logic [HW-1:0] wrap_idx(input int unsigned x);
    int unsigned y;
    y = (x >= QUEUE_DEPTH) ? x - QUEUE_DEPTH : x;
    return HW'(y);
  endfunction

  logic [HW-1:0]              slot_k, slot_k1, tail;
  logic [zps_pkg::SLOT_W-1:0] hd_prog;
  logic                       hd_prog_ok;
  logic [zps_pkg::TOT_W-1:0]  hd_total;
  logic [ZW-1:0]              nz_pos;
  logic [ZW-1:0]              pos_sel;
  logic [AW-1:0]              raddr, waddr;
  logic                       running;

  // Derive queue slots, head program and decisions
  always_comb begin
    slot_k     = wrap_idx(int'(head) + int'(k));
    slot_k1    = wrap_idx(int'(head) + int'(k) + 1);
    tail       = wrap_idx(int'(head) + int'(count));
    hd_prog    = qprog[head];
    hd_prog_ok = (int'(hd_prog) < NUM_PROGRAMS) && hdr_valid[PW'(hd_prog)];
    hd_total   = hdr_cnt[PW'(hd_prog)];
    nz_pos     = step_pos + ZW'(1);
    pos_sel    = (ctl.act == zps_pkg::A_GO) ? '0 : nz_pos;
    raddr      = AW'(int'(hd_prog) * MAX_ZONES + int'(pos_sel));
    waddr      = AW'(int'(slot_q) * MAX_ZONES + int'(sidx_q));
    running    = (count != '0);

    st.in_fire    = cmd.valid && cmd.ready;
    st.opcode     = op_q;
    st.count_zero = !running;
    st.cd_le1     = (countdown <= zps_pkg::DUR_W'(1));
    st.cur_match  = running && ((rid_q == '0) || (qid[head] == rid_q));
    st.step_match = (rid_q == '0) || (int'(sidx_q) == int'(step_pos));
    st.enq_range  = int'(slot_q) >= NUM_PROGRAMS;
    st.enq_full   = int'(count) >= QUEUE_DEPTH;
    st.wprog_err  = (int'(slot_q) >= NUM_PROGRAMS) || (int'(ptot_q) > MAX_ZONES);
    st.wzone_err  = (int'(slot_q) >= NUM_PROGRAMS) || (int'(sidx_q) >= MAX_ZONES) ||
                    (int'(valve_q) >= NUM_VALVES);
    st.nz_ok      = hd_prog_ok && (int'(nz_pos) < int'(hd_total));
    st.head_ok    = hd_prog_ok && (hd_total != '0);
    st.scan_end   = (k >= count);
    st.cancel_hit = ((rid_q == '0) && (k == '0)) || (qid[slot_k] == rid_q);
    st.k_zero     = (k == '0);
    st.shift_end  = (int'(k) + 1 >= int'(count));
    st.out_free   = !rsp.valid || rsp.ready;
  end

  assign cmd.ready = ctl.take;

  // Latch the word on accept
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q    <= cmd.opcode;
      slot_q  <= cmd.prog_slot;
      rid_q   <= cmd.run_id;
      sidx_q  <= cmd.step_index;
      valve_q <= cmd.valve_number;
      dur_q   <= cmd.duration_secs;
      pval_q  <= cmd.prog_valid;
      ptot_q  <= cmd.step_total;
    end
  end

  // Zone store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.act == zps_pkg::A_WZONE) zmem[waddr] <= {valve_q, dur_q};
    if (ctl.act == zps_pkg::A_NZREAD || ctl.act == zps_pkg::A_GO) zrd <= zmem[raddr];
  end

  // Queue entries, scan pointer and result fields
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      status   <= zps_pkg::ST_DONE;
      new_id   <= '0;
      use_flag <= 1'b0;
    end
    if (ctl.status_we) status <= ctl.status;
    unique case (ctl.act)
      zps_pkg::A_ENQ: begin
        qid[tail]   <= idc;
        qprog[tail] <= slot_q;
        new_id      <= idc;
      end
      zps_pkg::A_NZREAD: zpos <= nz_pos;
      zps_pkg::A_GO:     zpos <= '0;
      zps_pkg::A_LOAD:   valve_id <= zrd[zps_pkg::ZENT_W-1 -: zps_pkg::VALVE_W];
      zps_pkg::A_SCAN0:  k <= '0;
      zps_pkg::A_STEP:   k <= k + CW'(1);
      zps_pkg::A_QSTEP: begin
        if (qprog[slot_k] == slot_q) use_flag <= 1'b1;
        k <= k + CW'(1);
      end
      zps_pkg::A_SHIFT: begin
        qid[slot_k]   <= qid[slot_k1];
        qprog[slot_k] <= qprog[slot_k1];
        k             <= k + CW'(1);
      end
      default: ;
    endcase
  end

  // Control state: head, count, ids, pump, zone timing, table headers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      idc       <= zps_pkg::ID_W'(1);
      pump      <= 1'b0;
      step_pos  <= '0;
      valve_on  <= 1'b0;
      countdown <= '0;
      for (int i = 0; i < NUM_PROGRAMS; i++) begin
        hdr_valid[i] <= 1'b0;
        hdr_cnt[i]   <= '0;
      end
    end else begin
      unique case (ctl.act)
        zps_pkg::A_DEC: countdown <= countdown - zps_pkg::DUR_W'(1);
        zps_pkg::A_ENQ: begin
          idc   <= (idc == '1) ? zps_pkg::ID_W'(1) : idc + zps_pkg::ID_W'(1);
          count <= count + CW'(1);
        end
        zps_pkg::A_STOP, zps_pkg::A_IDLE: begin
          if (ctl.act == zps_pkg::A_STOP) count <= '0;
          pump      <= 1'b0;
          step_pos  <= '0;
          valve_on  <= 1'b0;
          countdown <= '0;
        end
        zps_pkg::A_WPROG: begin
          hdr_valid[PW'(slot_q)] <= pval_q;
          hdr_cnt[PW'(slot_q)]   <= ptot_q;
        end
        zps_pkg::A_NZREAD: valve_on <= 1'b0;
        zps_pkg::A_POP: begin
          valve_on <= 1'b0;
          if (count != '0) begin
            head  <= wrap_idx(int'(head) + 1);
            count <= count - CW'(1);
          end
        end
        zps_pkg::A_GO: pump <= 1'b1;
        zps_pkg::A_LOAD: begin
          step_pos  <= zpos;
          valve_on  <= 1'b1;
          countdown <= zrd[zps_pkg::DUR_W-1:0];
        end
        zps_pkg::A_SHEND: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= (ctl.act == zps_pkg::A_RESP) || (rsp.valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act == zps_pkg::A_RESP) begin
      rsp.status         <= status;
      rsp.running        <= running;
      rsp.pump_on        <= pump;
      rsp.valve_active   <= valve_on;
      rsp.valve_open_id  <= valve_on ? valve_id : '0;
      rsp.active_program <= running ? hd_prog : '0;
      rsp.active_step    <= running ? zps_pkg::SIDX_W'(step_pos) : '0;
      rsp.seconds_left   <= running ? countdown : '0;
      rsp.queued_runs    <= zps_pkg::QCNT_W'(count);
      rsp.new_run_id     <= new_id;
      rsp.in_use         <= use_flag;
    end
  end

endmodule

FILE: rtl/zone_program_sequencer_top.sv
// Zone program sequencer: program table, zone store and a queue of runs.
// cmd carries one command word (tick, enqueue, next zone, next program,
// stop, cancel, in-use query, program write, zone write); rsp returns one
// result word per command with the status and the state after it.
// Both channels use valid/ready; a word moves when both are high.
// Steps: a word is latched on accept, decoded, and its result is loaded
// into the output register before the next word can be taken; starting or
// advancing a zone adds a registered zone store read, moving on to the
// next run adds a launch step, each invalid head skipped adds one more
// launch step, and cancel or in-use query walk the queue one entry a cycle.
// One command is in work at a time. A stalled receiver leaves one result in
// the output register; one more word is taken and finished behind it, and
// then the input is blocked until the receiver takes the result.
// Reset (rst, synchronous) empties the queue, turns pump and valve off,
// clears every program to invalid and sets the run id counter to 1.
// Zone entries hold whatever was last written to them.
module zone_program_sequencer_top #(
  parameter int QUEUE_DEPTH  = zps_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_PROGRAMS = zps_pkg::NUM_PROGRAMS_DEF,
  parameter int MAX_ZONES    = zps_pkg::MAX_ZONES_DEF,
  parameter int NUM_VALVES   = zps_pkg::NUM_VALVES_DEF
) (
  input logic          clk,
  input logic          rst,
  zps_item_if.sink     cmd,
  zps_result_if.source rsp
);

  zps_pkg::dp_cmd_t  ctl;
  zps_pkg::dp_stat_t st;

  zps_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl)
  );

  zps_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .NUM_PROGRAMS (NUM_PROGRAMS),
    .MAX_ZONES    (MAX_ZONES),
    .NUM_VALVES   (NUM_VALVES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .ctl (ctl),
    .st  (st)
  );

  // Pump runs exactly while a run is active
  a_pump_running: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.running == rsp.pump_on))
    else $error("pump state disagrees with running");

  // An open valve needs an active run
  a_valve_run: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.valve_active) |-> rsp.running)
    else $error("valve open while idle");

  // One command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("second command taken while busy");

endmodule

FILE: tb/tb_zone_program_sequencer_top.sv
module tb_zone_program_sequencer_top;

  localparam int QD = 8;
  localparam int NP = 16;
  localparam int MZ = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic        running;
    logic        pump_on;
    logic        valve_active;
    logic [5:0]  valve_open_id;
    logic [3:0]  active_program;
    logic [3:0]  active_step;
    logic [15:0] seconds_left;
    logic [3:0]  queued_runs;
    logic [15:0] new_run_id;
    logic        in_use;
  } seq_out_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [3:0]  prog_slot;
    logic [15:0] run_id;
    logic [3:0]  step_index;
    logic [5:0]  valve_number;
    logic [15:0] duration_secs;
    logic        prog_valid;
    logic [4:0]  step_total;
  } seq_cmd_t;

  logic clk;
  logic rst;
  zps_item_if   cmd_if();
  zps_result_if rsp_if();

  zone_program_sequencer_top u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if.sink),
    .rsp (rsp_if.source)
  );

  // Predictor state
  logic [15:0] q_ids [QD];
  logic [3:0]  q_progs [QD];
  int          q_head;
  int          q_count;
  logic [15:0] id_next;
  bit          run_on;
  bit          pump_st;
  int          zpos;
  bit          vopen;
  logic [5:0]  vid;
  logic [15:0] secs;
  bit          hdr_valid [NP];
  logic [4:0]  hdr_total [NP];
  logic [5:0]  z_valve [NP*MZ];
  logic [15:0] z_dur [NP*MZ];
  bit          z_written [NP*MZ];

  seq_out_t expected_words[$];
  int  errors;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;
  int  watch_cnt;

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int qslot(int k);
    return (q_head + k) % QD;
  endfunction

  function automatic int zones_of(int p);
    return (hdr_total[p] > MZ) ? MZ : int'(hdr_total[p]);
  endfunction

  function automatic void go_idle();
    run_on = 0; pump_st = 0; zpos = 0; vopen = 0; vid = '0; secs = '0;
  endfunction

  function automatic void pop_head();
    if (q_count == 0) return;
    q_head = (q_head + 1) % QD;
    q_count--;
  endfunction

  function automatic void open_zone(int p, int pos);
    zpos = pos;
    vopen = 1;
    vid = z_valve[p*MZ+pos];
    secs = z_dur[p*MZ+pos];
  endfunction

  function automatic void launch_head();
    int p;
    while (q_count > 0) begin
      p = q_progs[qslot(0)];
      if (!hdr_valid[p] || zones_of(p) == 0) begin
        pop_head();
        continue;
      end
      run_on = 1; pump_st = 1;
      open_zone(p, 0);
      return;
    end
    go_idle();
  endfunction

  function automatic void drop_head();
    vopen = 0;
    pop_head();
    launch_head();
  endfunction

  function automatic void advance_zone();
    int p;
    p = q_progs[qslot(0)];
    vopen = 0;
    if (hdr_valid[p] && zpos + 1 < zones_of(p)) open_zone(p, zpos + 1);
    else drop_head();
  endfunction

  function automatic void remove_run(int k);
    if (k == 0) begin
      drop_head();
      return;
    end
    for (int i = k; i + 1 < q_count; i++) begin
      q_ids[qslot(i)]   = q_ids[qslot(i+1)];
      q_progs[qslot(i)] = q_progs[qslot(i+1)];
    end
    q_count--;
  endfunction

  // Work out the result word of one command and update the predictor
  function automatic seq_out_t predict_sequencer(seq_cmd_t c);
    seq_out_t o;
    logic [1:0] st;
    logic [15:0] nid;
    bit use_hit, cur;
    int t;
    st = zps_pkg::ST_DONE; nid = '0; use_hit = 0;
    cur = q_count > 0 && (c.run_id == 0 || q_ids[qslot(0)] == c.run_id);
    case (c.opcode)
      zps_pkg::OP_TICK:
        if (q_count > 0) begin
          if (secs <= 1) advance_zone();
          else secs--;
        end
      zps_pkg::OP_ENQ:
        if (q_count >= QD) st = zps_pkg::ST_FULL;
        else begin
          t = qslot(q_count);
          nid = id_next;
          id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
          q_ids[t] = nid;
          q_progs[t] = c.prog_slot;
          q_count++;
          if (q_count == 1) launch_head();
        end
      zps_pkg::OP_NZONE:
        if (cur && (c.run_id == 0 || c.step_index == zpos)) advance_zone();
        else st = zps_pkg::ST_IGNORE;
      zps_pkg::OP_NPROG:
        if (cur) drop_head();
        else st = zps_pkg::ST_IGNORE;
      zps_pkg::OP_STOP: begin
        q_count = 0;
        go_idle();
      end
      zps_pkg::OP_CANCEL: begin
        st = zps_pkg::ST_IGNORE;
        for (int i = 0; i < q_count; i++) begin
          if ((c.run_id == 0 && i == 0) || q_ids[qslot(i)] == c.run_id) begin
            remove_run(i);
            st = zps_pkg::ST_DONE;
            break;
          end
        end
      end
      zps_pkg::OP_QUERY:
        for (int i = 0; i < q_count; i++)
          if (q_progs[qslot(i)] == c.prog_slot) use_hit = 1;
      zps_pkg::OP_WPROG:
        if (c.step_total > MZ) st = zps_pkg::ST_RANGE;
        else begin
          hdr_valid[c.prog_slot] = c.prog_valid;
          hdr_total[c.prog_slot] = c.step_total;
        end
      zps_pkg::OP_WZONE: begin
        z_valve[c.prog_slot*MZ + c.step_index] = c.valve_number;
        z_dur[c.prog_slot*MZ + c.step_index] = c.duration_secs;
        z_written[c.prog_slot*MZ + c.step_index] = 1;
      end
      default: st = zps_pkg::ST_IGNORE;
    endcase
    o.status = st;
    o.running = run_on;
    o.pump_on = pump_st;
    o.valve_active = vopen;
    o.valve_open_id = vopen ? vid : 6'd0;
    o.active_program = run_on ? q_progs[qslot(0)] : 4'd0;
    o.active_step = run_on ? zpos[3:0] : 4'd0;
    o.seconds_left = run_on ? secs : 16'd0;
    o.queued_runs = q_count[3:0];
    o.new_run_id = nid;
    o.in_use = use_hit;
    return o;
  endfunction

  // Send one command word and queue its expected result at acceptance;
  // valid stays up after the accept until the next word or a drain drops it
  task automatic send_word(seq_cmd_t c);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= c.opcode;
    cmd_if.prog_slot     <= c.prog_slot;
    cmd_if.run_id        <= c.run_id;
    cmd_if.step_index    <= c.step_index;
    cmd_if.valve_number  <= c.valve_number;
    cmd_if.duration_secs <= c.duration_secs;
    cmd_if.prog_valid    <= c.prog_valid;
    cmd_if.step_total    <= c.step_total;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    expected_words.push_back(predict_sequencer(c));
  endtask

  function automatic seq_cmd_t mk(logic [3:0] op, logic [3:0] slot = 0,
                                  logic [15:0] rid = 0, logic [3:0] sidx = 0,
                                  logic [5:0] valve = 0, logic [15:0] dur = 0,
                                  logic pv = 0, logic [4:0] tot = 0);
    seq_cmd_t c;
    c.opcode = op; c.prog_slot = slot; c.run_id = rid; c.step_index = sidx;
    c.valve_number = valve; c.duration_secs = dur; c.prog_valid = pv;
    c.step_total = tot;
    return c;
  endfunction

  // A program may only be made valid with zones whose entries were written
  function automatic bit zones_ready(int p, int tot);
    for (int i = 0; i < tot; i++)
      if (!z_written[p*MZ+i]) return 0;
    return 1;
  endfunction

  // Drop valid, then wait for every expected result
  task automatic wait_drained();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // Random command with an emphasis on well-formed traffic
  task automatic send_random();
    seq_cmd_t c;
    int r;
    int p;
    r = $urandom_range(99);
    c = mk(zps_pkg::OP_TICK, 4'($urandom), 16'($urandom), 4'($urandom), 6'($urandom),
           16'($urandom), 1'($urandom), 5'($urandom_range(31)));
    if (r < 30) c.opcode = zps_pkg::OP_TICK;
    else if (r < 50) c.opcode = zps_pkg::OP_ENQ;
    else if (r < 58) begin
      c.opcode = zps_pkg::OP_NZONE;
      if ($urandom_range(1)) c.run_id = 0;
      else if (q_count > 0 && $urandom_range(1)) begin
        c.run_id = q_ids[qslot(0)];
        c.step_index = $urandom_range(1) ? zpos[3:0] : c.step_index;
      end
    end else if (r < 64) begin
      c.opcode = zps_pkg::OP_NPROG;
      if (q_count > 0 && $urandom_range(2) != 0)
        c.run_id = $urandom_range(1) ? 16'd0 : q_ids[qslot(0)];
    end else if (r < 66) c.opcode = zps_pkg::OP_STOP;
    else if (r < 74) begin
      c.opcode = zps_pkg::OP_CANCEL;
      if (q_count > 0 && $urandom_range(2) != 0)
        c.run_id = q_ids[qslot($urandom_range(q_count-1))];
      else if ($urandom_range(3) == 0) c.run_id = 0;
    end else if (r < 80) c.opcode = zps_pkg::OP_QUERY;
    else if (r < 87) c.opcode = zps_pkg::OP_WZONE;
    else if (r < 96) c.opcode = zps_pkg::OP_WPROG;
    else c.opcode = 4'($urandom_range(9, 15));
    // Short durations keep zone changes frequent
    if (c.opcode == zps_pkg::OP_WZONE && $urandom_range(9) != 0)
      c.duration_secs = 16'($urandom_range(4));
    if (c.opcode == zps_pkg::OP_WPROG) begin
      p = c.prog_slot;
      if ($urandom_range(4) != 0) c.step_total = 5'($urandom_range(4));
      if (c.step_total <= MZ && c.prog_valid && !zones_ready(p, c.step_total))
        c.prog_valid = 0;
    end
    send_word(c);
  endtask

  // Check each result word
  always @(posedge clk) begin
    seq_out_t got, exp_w;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.status, rsp_if.running, rsp_if.pump_on, rsp_if.valve_active,
             rsp_if.valve_open_id, rsp_if.active_program, rsp_if.active_step,
             rsp_if.seconds_left, rsp_if.queued_runs, rsp_if.new_run_id, rsp_if.in_use};
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          $display({"%0t: expected status=%0d run=%0b pump=%0b vact=%0b vid=%0d",
                    " prog=%0d step=%0d secs=%0d q=%0d id=%0d use=%0b"},
                   $realtime, exp_w.status, exp_w.running, exp_w.pump_on,
                   exp_w.valve_active, exp_w.valve_open_id, exp_w.active_program,
                   exp_w.active_step, exp_w.seconds_left, exp_w.queued_runs,
                   exp_w.new_run_id, exp_w.in_use);
          $display({"%0t: actual   status=%0d run=%0b pump=%0b vact=%0b vid=%0d",
                    " prog=%0d step=%0d secs=%0d q=%0d id=%0d use=%0b"},
                   $realtime, got.status, got.running, got.pump_on,
                   got.valve_active, got.valve_open_id, got.active_program,
                   got.active_step, got.seconds_left, got.queued_runs,
                   got.new_run_id, got.in_use);
          errors++;
        end
      end
    end
  end

  // Drive receiver ready
  always @(negedge clk) begin
    if (recv_hold) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count cycles without any accepted word
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt >= WATCH_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    // Zones for programs 1, 2 and 15, and the widest valve and duration
    send_word(mk(zps_pkg::OP_WZONE, 1, 0, 0, 6'd63, 16'hFFFF));
    send_word(mk(zps_pkg::OP_WZONE, 1, 0, 1, 6'd5, 16'd0));
    send_word(mk(zps_pkg::OP_WZONE, 2, 0, 0, 6'd0, 16'd2));
    send_word(mk(zps_pkg::OP_WZONE, 15, 0, 15, 6'd42, 16'd1));
    send_word(mk(zps_pkg::OP_WPROG, 1, 0, 0, 0, 0, 1, 5'd2));
    send_word(mk(zps_pkg::OP_WPROG, 2, 0, 0, 0, 0, 1, 5'd1));
    send_word(mk(zps_pkg::OP_WPROG, 3, 0, 0, 0, 0, 1, 5'd17));
    send_word(mk(zps_pkg::OP_WPROG, 4, 0, 0, 0, 0, 1, 5'd0));
    send_word(mk(zps_pkg::OP_TICK));
    // Invalid and empty programs are dropped at the head
    send_word(mk(zps_pkg::OP_ENQ, 0));
    send_word(mk(zps_pkg::OP_ENQ, 4));
    send_word(mk(zps_pkg::OP_ENQ, 1));
    send_word(mk(zps_pkg::OP_ENQ, 2));
    send_word(mk(zps_pkg::OP_QUERY, 2));
    send_word(mk(zps_pkg::OP_QUERY, 9));
    send_word(mk(zps_pkg::OP_NZONE, 0, 16'hFFFF, 4'd15));
    send_word(mk(zps_pkg::OP_NZONE, 0, 0));
    send_word(mk(zps_pkg::OP_TICK));
    send_word(mk(zps_pkg::OP_CANCEL, 0, 16'd4));
    send_word(mk(zps_pkg::OP_NPROG, 0, 16'd1234));
    send_word(mk(zps_pkg::OP_NPROG, 0, 0));
    send_word(mk(zps_pkg::OP_CANCEL, 0, 16'hFFFF));
    send_word(mk(zps_pkg::OP_TICK));
    send_word(mk(zps_pkg::OP_TICK));
    send_word(mk(zps_pkg::OP_TICK));
    send_word(mk(zps_pkg::OP_STOP));
    send_word(mk(4'd15));
    wait_drained();
  endtask

  // Fill the queue while results back up, then check the full flag
  task automatic test_queue_full();
    recv_hold = 1;
    fork
      begin
        repeat (200) @(negedge clk);
        recv_hold = 0;
      end
      for (int i = 0; i < QD + 2; i++) send_word(mk(zps_pkg::OP_ENQ, 4'(i % 3)));
    join
    wait_drained();
    send_word(mk(zps_pkg::OP_STOP));
    wait_drained();
  endtask

  // Step the id counter with enqueue and stop pairs until it passes 200
  task automatic test_id_wrap();
    send_idle_pct = 0; recv_idle_pct = 0;
    while (id_next != 16'hFFFE) begin
      send_word(mk(zps_pkg::OP_ENQ, 0));
      send_word(mk(zps_pkg::OP_STOP));
      if (id_next > 16'd200 && id_next < 16'hFF00) break;
    end
    wait_drained();
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct; recv_idle_pct = r_pct;
    repeat (n) send_random();
    wait_drained();
  endtask

  initial begin
    errors = 0; recv_hold = 0; watch_cnt = 0;
    send_idle_pct = 14; recv_idle_pct = 82;
    q_head = 0; q_count = 0; id_next = 16'd1;
    for (int i = 0; i < QD; i++) begin q_ids[i] = '0; q_progs[i] = '0; end
    for (int i = 0; i < NP; i++) begin hdr_valid[i] = 0; hdr_total[i] = '0; end
    for (int i = 0; i < NP*MZ; i++) begin
      z_valve[i] = '0; z_dur[i] = '0; z_written[i] = 0;
    end
    go_idle();
    cmd_if.valid = 0; cmd_if.opcode = '0; cmd_if.prog_slot = '0; cmd_if.run_id = '0;
    cmd_if.step_index = '0; cmd_if.valve_number = '0; cmd_if.duration_secs = '0;
    cmd_if.prog_valid = 0; cmd_if.step_total = '0;
    rsp_if.ready = 0;
    rst = 1;
    repeat (10) @(negedge clk);
    rst = 0;
    test_directed();
    test_queue_full();
    test_random(300, 14, 82);
    test_random(300, 82, 14);
    test_random(300, 0, 0);
    test_id_wrap();
    repeat (50) @(negedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
